### hdl/dss_pkg.sv
// shared types and constants for the dual stack shared store
package dss_pkg;

   // action codes
   localparam logic [2:0] ACT_PUSH_LOWER = 3'd0;
   localparam logic [2:0] ACT_PUSH_UPPER = 3'd1;
   localparam logic [2:0] ACT_POP_LOWER  = 3'd2;
   localparam logic [2:0] ACT_POP_UPPER  = 3'd3;
   localparam logic [2:0] ACT_PEEK_LOWER = 3'd4;
   localparam logic [2:0] ACT_PEEK_UPPER = 3'd5;

   // status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [1:0] ST_UNDERFLOW = 2'd2;

   localparam logic signed [31:0] EMPTY_WORD = -32'sd1;

   typedef struct packed {
      logic [2:0]         action;
      logic signed [31:0] push_value;
   } req_beat_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic [1:0]         status;
      logic               lower_empty;
      logic               upper_empty;
   } rsp_beat_type;

   // per-item result info carried alongside the store read
   typedef struct packed {
      logic       use_mem;
      logic [1:0] status;
      logic       lower_empty;
      logic       upper_empty;
   } step_info_type;

endpackage

### hdl/dss_store.sv
// single-port synchronous word store with registered read data
module dss_store #(
   parameter int DEPTH = 8,
   parameter int AW    = 3
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic                 rd_en,
   input  logic [AW-1:0]        addr,
   input  logic signed [31:0]   wdata,
   output logic signed [31:0]   rdata
);

   logic signed [31:0] mem [DEPTH];
   logic signed [31:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### hdl/dss_ctrl.sv
// stack pointers, action decode and store command generation
module dss_ctrl #(
   parameter int DEPTH = 8,
   parameter int CW    = 4,
   parameter int AW    = 3
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  dss_pkg::req_beat_type  req,
   output logic                   mem_wr_en,
   output logic                   mem_rd_en,
   output logic [AW-1:0]          mem_addr,
   output logic signed [31:0]     mem_wdata,
   output dss_pkg::step_info_type info
);

   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [CW:0]   DEPTH_W = (CW+1)'(DEPTH);

   logic [CW-1:0] lower_ff, lower_in;
   logic [CW-1:0] upper_ff, upper_in;
   logic [CW-1:0] addr_full;
   logic          full;
   logic          wr, rd;
   logic [1:0]    status;

   assign full = ({1'b0, lower_ff} + {1'b0, upper_ff}) >= DEPTH_W;

   always_comb begin
      lower_in  = lower_ff;
      upper_in  = upper_ff;
      addr_full = '0;
      wr        = 1'b0;
      rd        = 1'b0;
      status    = dss_pkg::ST_OK;
      unique case (req.action)
         dss_pkg::ACT_PUSH_LOWER: begin
            if (full) begin
               status = dss_pkg::ST_OVERFLOW;
            end else begin
               wr        = 1'b1;
               addr_full = lower_ff;
               lower_in  = lower_ff + CW'(1);
            end
         end
         dss_pkg::ACT_PUSH_UPPER: begin
            if (full) begin
               status = dss_pkg::ST_OVERFLOW;
            end else begin
               wr        = 1'b1;
               addr_full = DEPTH_C - CW'(1) - upper_ff;
               upper_in  = upper_ff + CW'(1);
            end
         end
         dss_pkg::ACT_POP_LOWER, dss_pkg::ACT_PEEK_LOWER: begin
            if (lower_ff == '0) begin
               status = dss_pkg::ST_UNDERFLOW;
            end else begin
               rd        = 1'b1;
               addr_full = lower_ff - CW'(1);
               if (req.action == dss_pkg::ACT_POP_LOWER) begin
                  lower_in = lower_ff - CW'(1);
               end
            end
         end
         dss_pkg::ACT_POP_UPPER, dss_pkg::ACT_PEEK_UPPER: begin
            if (upper_ff == '0) begin
               status = dss_pkg::ST_UNDERFLOW;
            end else begin
               rd        = 1'b1;
               addr_full = DEPTH_C - upper_ff;
               if (req.action == dss_pkg::ACT_POP_UPPER) begin
                  upper_in = upper_ff - CW'(1);
               end
            end
         end
         default: begin
            // unused codes: no change
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff <= '0;
         upper_ff <= '0;
      end else if (accept) begin
         lower_ff <= lower_in;
         upper_ff <= upper_in;
      end
   end

   assign mem_wr_en        = accept & wr;
   assign mem_rd_en        = accept & rd;
   assign mem_addr         = addr_full[AW-1:0];
   assign mem_wdata        = req.push_value;
   assign info.use_mem     = rd;
   assign info.status      = status;
   assign info.lower_empty = (lower_in == '0);
   assign info.upper_empty = (upper_in == '0);

endmodule

### hdl/dual_stack_shared_store.sv
// top level of the dual stack shared store
// Two LIFO stacks share one store of DEPTH 32-bit words: the lower stack grows up from
// entry 0, the upper stack grows down from entry DEPTH-1. Each request beat (push, pop or
// peek of either stack) produces exactly one response beat with the read word, a status
// (ok, overflow, underflow) and both empty flags after the step. Throughput is one beat
// per clock while req_stall is low; a response goes through the store's read data register
// and the read stage info register into the response register. One beat can wait in the
// read stage while the response register is stalled, with req_stall high meanwhile. The
// store holds no reset contents; only entries that a stack holds are read.
module dual_stack_shared_store #(
   parameter int DEPTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  dss_pkg::req_beat_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output dss_pkg::rsp_beat_type rsp_data
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // handshake on the request side
   logic req_accept;

   // store command from the pointer logic
   logic                   mem_wr_en;
   logic                   mem_rd_en;
   logic [AW-1:0]          mem_addr;
   logic signed [31:0]     mem_wdata;
   logic signed [31:0]     mem_rdata;
   dss_pkg::step_info_type step_info;

   // read stage: the item whose store read is in flight or held
   logic                   s1_vld_ff, s1_vld_in;
   dss_pkg::step_info_type s1_info_ff;
   logic                   s1_move;

   // response register
   logic                   rsp_vld_ff, rsp_vld_in;
   dss_pkg::rsp_beat_type  rsp_data_ff, rsp_data_in;

   // the read stage drains whenever the response register is free or being emptied
   assign s1_move    = s1_vld_ff & (~rsp_vld_ff | ~rsp_stall);
   // stall only when the read stage is full and cannot drain this cycle
   assign req_stall  = s1_vld_ff & ~s1_move;
   assign req_accept = req_valid & ~req_stall;

   dss_ctrl #(
      .DEPTH (DEPTH),
      .CW    (CW),
      .AW    (AW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .req       (req_data),
      .mem_wr_en (mem_wr_en),
      .mem_rd_en (mem_rd_en),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .info      (step_info)
   );

   // the read data register only loads on a read, so it holds while the stage waits
   dss_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock (clock),
      .wr_en (mem_wr_en),
      .rd_en (mem_rd_en),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (req_accept) begin
         s1_vld_in = 1'b1;
      end else if (s1_move) begin
         s1_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_info_ff <= step_info;
      end
   end

   // build the response word: store data, all ones on underflow, zero otherwise
   always_comb begin
      rsp_data_in.status      = s1_info_ff.status;
      rsp_data_in.lower_empty = s1_info_ff.lower_empty;
      rsp_data_in.upper_empty = s1_info_ff.upper_empty;
      priority if (s1_info_ff.use_mem) begin
         rsp_data_in.read_value = mem_rdata;
      end else if (s1_info_ff.status == dss_pkg::ST_UNDERFLOW) begin
         rsp_data_in.read_value = dss_pkg::EMPTY_WORD;
      end else begin
         rsp_data_in.read_value = '0;
      end
   end

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (s1_move) begin
         rsp_vld_in = 1'b1;
      end else if (~rsp_stall) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

   // overflow means the store is full, so at least one stack holds words
   a_overflow_nonempty : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == dss_pkg::ST_OVERFLOW
      |-> !(rsp_data.lower_empty && rsp_data.upper_empty))
      else $error("overflow reported with both stacks empty");

   // underflow always carries the all-ones word
   a_underflow_word : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == dss_pkg::ST_UNDERFLOW
      |-> rsp_data.read_value == dss_pkg::EMPTY_WORD)
      else $error("underflow without all-ones read value");

   // an accepted beat always occupies the read stage next cycle
   a_accept_tracked : assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_vld_ff)
      else $error("accepted beat lost before read stage");

   // a held read stage never overwrites a stalled response
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_stall && s1_vld_ff |=> s1_vld_ff && rsp_vld_ff)
      else $error("pending beat dropped under response stall");

endmodule
